// ===== rtl/lsg_pkg.sv =====
// Shared types, constants and codes for the leadscrew step gearing block.
// No dependencies; every other file imports it.
package lsg_pkg;

  localparam int unsigned LSG_FRAC_BITS = 16;

  localparam int unsigned TP_W       = 18;
  localparam int unsigned STEPS_W    = 16;
  localparam int unsigned LEAD_W     = 17;
  localparam int unsigned CPR_W      = 16;
  localparam int unsigned MAXS_W     = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = STEPS_W + TP_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register reset values
  localparam logic [TP_W-1:0]    TP_RST    = 18'd1000;
  localparam logic [STEPS_W-1:0] MSTEP_RST = 16'd200;
  localparam logic [LEAD_W-1:0]  LEAD_RST  = 17'd2000;
  localparam logic [CPR_W-1:0]   CPR_RST   = 16'd4096;
  localparam logic [MAXS_W-1:0]  MAXS_RST  = 16'd1000;

  // item action codes
  localparam logic ACT_RESYNC = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THREAD_PITCH = 3'd0,
    REG_MOTOR_STEPS  = 3'd1,
    REG_LEAD_PITCH   = 3'd2,
    REG_ENC_CPR      = 3'd3,
    REG_MAX_STEPS    = 3'd4,
    REG_REVERSE      = 3'd5,
    REG_INVERT       = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_RMUL, ST_DIV1, ST_DIV2, ST_IDLE, ST_DABS, ST_MLO,
    ST_MHI, ST_SUM, ST_ACC, ST_MAG, ST_FIN, ST_RES
  } state_t;

  typedef struct packed {
    logic in_fire;
    logic upd;
    logic cfg_fire;
    logic dzero;
    logic out_free;
  } lsg_sts_t;

  typedef struct packed {
    state_t st;
    logic   last;
    logic   in_ready;
    logic   cfg_ready;
  } lsg_ctl_t;

endpackage

// ===== rtl/lsg_if.sv =====
// Handshake channels of the step gearing block: input, result and config write.
// Depends on lsg_pkg.
interface lsg_in_if import lsg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [CNT_W-1:0] spindle_total;

  modport source (output valid, action, spindle_total, input ready);
  modport sink   (input valid, action, spindle_total, output ready);
endinterface

interface lsg_out_if import lsg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STEPS_W-1:0] step_magnitude;
  logic               dir_pin;

  modport source (output valid, step_magnitude, dir_pin, input ready);
  modport sink   (input valid, step_magnitude, dir_pin, output ready);
endinterface

interface lsg_cfg_if import lsg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lsg_addsub.sv =====
// Shared 64-bit add/subtract unit; carry out doubles as the a >= b compare.
// Depends on lsg_pkg.
module lsg_addsub import lsg_pkg::*; (
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  input  logic             sub,
  output logic [ACC_W-1:0] sum,
  output logic             cout
);

  logic [ACC_W:0] full;

  assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ACC_W{1'b0}}, sub};
  assign sum  = full[ACC_W-1:0];
  assign cout = full[ACC_W];

endmodule

// ===== rtl/lsg_seq.sv =====
// Sequencer: ratio recompute (multiply, two restoring divides) and item steps.
// Depends on lsg_pkg.
module lsg_seq import lsg_pkg::*; #(
  parameter int unsigned FRACTION_BITS = LSG_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  input  lsg_sts_t sts,
  output lsg_ctl_t ctl
);

  localparam int unsigned DIV_STEPS = PROD_W + FRACTION_BITS;
  localparam int unsigned CW        = $clog2(DIV_STEPS);

  state_t        state_r, state_nxt;
  logic [CW-1:0] bit_r, bit_nxt;
  logic          last;

  assign last = (bit_r == CW'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RMUL;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    case (state_r)
      ST_RMUL: begin
        bit_nxt   = '0;
        state_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        if (last) begin
          bit_nxt   = '0;
          state_nxt = ST_DIV2;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_DIV2: begin
        if (last) begin
          state_nxt = ST_IDLE;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (sts.cfg_fire) begin
          state_nxt = ST_RMUL;
        end else if (sts.in_fire) begin
          state_nxt = sts.upd ? ST_DABS : ST_RES;
        end
      end
      ST_DABS: state_nxt = sts.dzero ? ST_RES : ST_MLO;
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_RES;
      ST_RES: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.st        = state_r;
    ctl.last      = last;
    ctl.cfg_ready = (state_r == ST_IDLE);
    ctl.in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  end

endmodule

// ===== rtl/leadscrew_step_gearing_core.sv =====
// Leadscrew step gearing core: fractional step accumulator on one shared adder.
// Update item: accept in IDLE, then DABS, MLO, MHI, SUM, ACC, MAG, FIN and RES, where
// the result is registered once the output register is free. Zero delta update:
// DABS goes straight to RES; resync: IDLE goes straight to RES. A result waits in an
// output register while the next item is taken. Reset and each config write start a
// ratio recompute (RMUL, DIV1, DIV2); no item is taken meanwhile. Sync active-low reset.
module leadscrew_step_gearing_core import lsg_pkg::*; #(
  parameter int unsigned FRACTION_BITS = LSG_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  lsg_in_if.sink       in_ch,
  lsg_out_if.source    out_ch,
  lsg_cfg_if.sink      cfg_ch
);

  // QW: width of the scaled dividend and of the ratio magnitude
  localparam int unsigned QW = PROD_W + FRACTION_BITS;
  // MW: whole-step part of the accumulator magnitude
  localparam int unsigned MW = ACC_W - FRACTION_BITS;

  lsg_sts_t sts;
  lsg_ctl_t ctl;

  // configuration
  logic [TP_W-1:0]    tp_r, tp_nxt;
  logic [STEPS_W-1:0] msteps_r, msteps_nxt;
  logic [LEAD_W-1:0]  lead_r, lead_nxt;
  logic [CPR_W-1:0]   cpr_r, cpr_nxt;
  logic [MAXS_W-1:0]  maxs_r, maxs_nxt;
  logic               rev_r, rev_nxt;
  logic               inv_r, inv_nxt;

  // architectural state
  logic [CNT_W-1:0]   last_count_r, last_count_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               dir_r, dir_nxt;

  // working registers
  logic [QW-1:0]      quo_r, quo_nxt;     // dividend / quotient, then ratio magnitude
  logic [LEAD_W-1:0]  rem_r, rem_nxt;
  logic [LEAD_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]   delta_r, delta_nxt;
  logic [MUL_W-1:0]   dm_r, dm_nxt;
  logic               dneg_r, dneg_nxt;
  logic [ACC_W-1:0]   lo_r, lo_nxt;
  logic [MUL_W-1:0]   hi_r, hi_nxt;
  logic [ACC_W-1:0]   prod_r, prod_nxt;
  logic [MW-1:0]      mag_r, mag_nxt;
  logic               accneg_r, accneg_nxt;
  logic [STEPS_W-1:0] steps_r, steps_nxt;

  // result register
  logic               out_valid_r;
  logic [STEPS_W-1:0] out_step_r;
  logic               out_dir_r;

  // shared units
  logic [ACC_W-1:0]   add_a, add_b, add_sum;
  logic               add_sub, add_cout;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [ACC_W-1:0]   mul_p;

  logic [TP_W-1:0]    tp_abs, tp_mag;
  logic [LEAD_W:0]    shifted;
  logic [CNT_W-1:0]   tot, diff;
  logic [STEPS_W-1:0] fin_s;
  logic               out_free;

  assign tot      = in_ch.spindle_total;
  assign out_free = !out_valid_r || out_ch.ready;
  assign shifted  = {rem_r, quo_r[QW-1]};

  // thread pitch magnitude, zero acts as one
  always_comb begin
    tp_abs = tp_r[TP_W-1] ? (~tp_r + TP_W'(1)) : tp_r;
    tp_mag = (tp_abs == '0) ? TP_W'(1) : tp_abs;
  end

  // clamp whole steps to the configured maximum
  assign fin_s = (mag_r > MW'(maxs_r)) ? maxs_r : mag_r[STEPS_W-1:0];

  always_comb begin
    sts.in_fire  = in_ch.valid && ctl.in_ready;
    sts.upd      = (in_ch.action == ACT_UPDATE);
    sts.cfg_fire = cfg_ch.valid && ctl.cfg_ready;
    sts.dzero    = (delta_r == '0);
    sts.out_free = out_free;
  end

  lsg_seq #(.FRACTION_BITS(FRACTION_BITS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  lsg_addsub u_addsub (
    .a    (add_a),
    .b    (add_b),
    .sub  (add_sub),
    .sum  (add_sum),
    .cout (add_cout)
  );

  // one 32x32 multiplier, shared by the ratio numerator and both partial products
  assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.st)
      ST_RMUL: begin
        mul_a = MUL_W'(msteps_r);
        mul_b = MUL_W'(tp_mag);
      end
      ST_MLO: begin
        mul_a = dm_r;
        mul_b = quo_r[MUL_W-1:0];
      end
      ST_MHI: begin
        mul_a = dm_r;
        mul_b = MUL_W'(quo_r[QW-1:MUL_W]);
      end
      default: ;
    endcase
  end

  // operand select for the shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ctl.st)
      ST_IDLE: begin                       // count delta
        add_a   = ACC_W'(tot);
        add_b   = ACC_W'(last_count_r);
        add_sub = 1'b1;
      end
      ST_DIV1, ST_DIV2: begin              // trial subtract
        add_a   = ACC_W'(shifted);
        add_b   = ACC_W'(dvs_r);
        add_sub = 1'b1;
      end
      ST_DABS: begin                       // |delta|
        add_b   = ACC_W'(delta_r);
        add_sub = delta_r[CNT_W-1];
      end
      ST_SUM: begin                        // join partial products, mod 2^64
        add_a = lo_r;
        add_b = {hi_r, {MUL_W{1'b0}}};
      end
      ST_ACC: begin
        add_a   = acc_r;
        add_b   = prod_r;
        add_sub = dneg_r ^ tp_r[TP_W-1];
      end
      ST_MAG: begin                        // |accumulator|
        add_b   = acc_r;
        add_sub = acc_r[ACC_W-1];
      end
      ST_FIN: begin                        // take emitted steps out
        add_a   = acc_r;
        add_b   = ACC_W'(fin_s) << FRACTION_BITS;
        add_sub = !accneg_r;
      end
      default: ;
    endcase
  end

  assign diff = add_sum[CNT_W-1:0];

  // configuration writes
  always_comb begin
    tp_nxt     = tp_r;
    msteps_nxt = msteps_r;
    lead_nxt   = lead_r;
    cpr_nxt    = cpr_r;
    maxs_nxt   = maxs_r;
    rev_nxt    = rev_r;
    inv_nxt    = inv_r;
    if (sts.cfg_fire) begin
      case (cfg_idx_t'(cfg_ch.index))
        REG_THREAD_PITCH: tp_nxt     = cfg_ch.data[TP_W-1:0];
        REG_MOTOR_STEPS:  msteps_nxt = cfg_ch.data[STEPS_W-1:0];
        REG_LEAD_PITCH:   lead_nxt   = cfg_ch.data[LEAD_W-1:0];
        REG_ENC_CPR:      cpr_nxt    = cfg_ch.data[CPR_W-1:0];
        REG_MAX_STEPS:    maxs_nxt   = cfg_ch.data[MAXS_W-1:0];
        REG_REVERSE:      rev_nxt    = cfg_ch.data[0];
        REG_INVERT:       inv_nxt    = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // datapath
  always_comb begin
    last_count_nxt = last_count_r;
    acc_nxt        = acc_r;
    dir_nxt        = dir_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    delta_nxt      = delta_r;
    dm_nxt         = dm_r;
    dneg_nxt       = dneg_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    prod_nxt       = prod_r;
    mag_nxt        = mag_r;
    accneg_nxt     = accneg_r;
    steps_nxt      = steps_r;
    case (ctl.st)
      ST_IDLE: begin
        if (sts.in_fire) begin
          last_count_nxt = tot;
          steps_nxt      = '0;
          if (in_ch.action == ACT_RESYNC) begin
            acc_nxt = '0;
          end else begin
            delta_nxt = rev_r ? (~diff + CNT_W'(1)) : diff;
          end
        end
      end
      ST_RMUL: begin
        // steps * |pitch| scaled to the fraction, then / lead, then / counts
        quo_nxt = {mul_p[PROD_W-1:0], {FRACTION_BITS{1'b0}}};
        rem_nxt = '0;
        dvs_nxt = (lead_r == '0) ? LEAD_W'(1) : lead_r;
      end
      ST_DIV1, ST_DIV2: begin
        rem_nxt = add_cout ? add_sum[LEAD_W-1:0] : shifted[LEAD_W-1:0];
        quo_nxt = {quo_r[QW-2:0], add_cout};
        if (ctl.st == ST_DIV1 && ctl.last) begin
          rem_nxt = '0;
          dvs_nxt = (cpr_r == '0) ? LEAD_W'(1) : LEAD_W'(cpr_r);
        end
      end
      ST_DABS: begin
        dm_nxt   = add_sum[MUL_W-1:0];
        dneg_nxt = delta_r[CNT_W-1];
      end
      ST_MLO: lo_nxt   = mul_p;
      ST_MHI: hi_nxt   = mul_p[MUL_W-1:0];
      ST_SUM: prod_nxt = add_sum;
      ST_ACC: acc_nxt  = add_sum;
      ST_MAG: begin
        mag_nxt    = add_sum[ACC_W-1:FRACTION_BITS];
        accneg_nxt = acc_r[ACC_W-1];
      end
      ST_FIN: begin
        acc_nxt   = add_sum;
        steps_nxt = fin_s;
        if (fin_s != '0) begin
          dir_nxt = accneg_r ^ inv_r;
        end
      end
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r         <= TP_RST;
      msteps_r     <= MSTEP_RST;
      lead_r       <= LEAD_RST;
      cpr_r        <= CPR_RST;
      maxs_r       <= MAXS_RST;
      rev_r        <= 1'b0;
      inv_r        <= 1'b0;
      last_count_r <= '0;
      acc_r        <= '0;
      dir_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tp_r         <= tp_nxt;
      msteps_r     <= msteps_nxt;
      lead_r       <= lead_nxt;
      cpr_r        <= cpr_nxt;
      maxs_r       <= maxs_nxt;
      rev_r        <= rev_nxt;
      inv_r        <= inv_nxt;
      last_count_r <= last_count_nxt;
      acc_r        <= acc_nxt;
      dir_r        <= dir_nxt;
      if (ctl.st == ST_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    delta_r  <= delta_nxt;
    dm_r     <= dm_nxt;
    dneg_r   <= dneg_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    prod_r   <= prod_nxt;
    mag_r    <= mag_nxt;
    accneg_r <= accneg_nxt;
    steps_r  <= steps_nxt;
    if (ctl.st == ST_RES && out_free) begin
      out_step_r <= steps_r;
      out_dir_r  <= dir_r;
    end
  end

  assign in_ch.ready           = ctl.in_ready;
  assign cfg_ch.ready          = ctl.cfg_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.step_magnitude = out_step_r;
  assign out_ch.dir_pin        = out_dir_r;

  // clamp holds on every emitted step count
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.st == ST_FIN) |=> (steps_r <= $past(maxs_r)))
    else $error("step count above clamp");

  // result register picks up the pending item when the slot is free
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.st == ST_RES && out_free) |=>
      (out_valid_r && out_step_r == $past(steps_r) && out_dir_r == $past(dir_r)))
    else $error("result not loaded");

  // direction only moves in the finishing step
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.st != ST_FIN) |=> $stable(dir_r))
    else $error("direction changed outside finish");

endmodule
